[rtl/psk_pkg.sv]
// Package for the priority stack: field widths, default sizes, status and
// operation codes, and the beat and cell control struct types.
// No dependencies; every other file of the block imports it.
package psk_pkg;

   localparam int CAPACITY_DEF       = 16;
   localparam int VALUE_WIDTH_DEF    = 32;
   localparam int PRIORITY_WIDTH_DEF = 8;

   localparam int VALUE_FIELD_WIDTH    = 32;
   localparam int PRIORITY_FIELD_WIDTH = 8;
   localparam int COUNT_FIELD_WIDTH    = 5;
   localparam int STATUS_WIDTH         = 2;

   localparam int VALUE_BUS_WIDTH    = 64;
   localparam int PRIORITY_BUS_WIDTH = 32;
   localparam int COUNT_BUS_WIDTH    = 16;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic                            kind;
      logic [VALUE_FIELD_WIDTH-1:0]    item_value;
      logic [PRIORITY_FIELD_WIDTH-1:0] item_priority;
   } psk_req_type;

   typedef struct packed {
      logic [VALUE_FIELD_WIDTH-1:0]    front_value;
      logic [PRIORITY_FIELD_WIDTH-1:0] front_priority;
      logic [COUNT_FIELD_WIDTH-1:0]    entry_count;
      logic                            is_empty;
      logic [STATUS_WIDTH-1:0]         status;
   } psk_rsp_type;

   typedef struct packed {
      logic push_en;
      logic pop_en;
   } psk_ctrl_type;

endpackage

[rtl/priority_stack_top.sv]
// Top level of the priority stack: request and response channels, entry
// count, and the chain of psk_cell slots. Depends on psk_pkg and psk_cell.
//
// Usage: each request beat on req_ is a push (kind 0) of a value and a
// priority, or a pop (kind 1) of the front entry. Entries are kept sorted
// with the highest priority at the front; equal priorities leave last in,
// first out. Every request beat yields exactly one response beat on rsp_
// carrying the front entry, its priority, the entry count, an empty flag
// and a status: done, push rejected because full, or pop rejected because
// empty. A rejected beat leaves the store unchanged.
// The response is registered and valid in the cycle after the request is
// accepted. Throughput is one beat per cycle while req_stall is low, set by
// the single update of all cells in parallel from their neighbors.
// A response waits in its output register while rsp_stall is high; during
// that time req_stall is high and the store holds still.
// Reset empties the store at once and drops any pending response.
module priority_stack_top #(
   parameter int CAPACITY       = psk_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH    = psk_pkg::VALUE_WIDTH_DEF,
   parameter int PRIORITY_WIDTH = psk_pkg::PRIORITY_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  psk_pkg::psk_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output psk_pkg::psk_rsp_type rsp_data
);
   import psk_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]           count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;

   logic accept, full, empty;
   psk_ctrl_type ctrl;

   logic [VALUE_BUS_WIDTH-1:0]    wide_new_value, wide_front_value;
   logic [PRIORITY_BUS_WIDTH-1:0] wide_new_prio, wide_front_prio;
   logic [COUNT_BUS_WIDTH-1:0]    wide_count;
   logic [VALUE_WIDTH-1:0]        new_value;
   logic [PRIORITY_WIDTH-1:0]     new_prio;

   logic [VALUE_WIDTH-1:0]    cell_value [CAPACITY];
   logic [PRIORITY_WIDTH-1:0] cell_prio  [CAPACITY];
   logic                      cell_stay  [CAPACITY];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);

   assign ctrl.push_en = accept && (req_data.kind == KIND_PUSH) && !full;
   assign ctrl.pop_en  = accept && (req_data.kind == KIND_POP) && !empty;

   assign wide_new_value = VALUE_BUS_WIDTH'(req_data.item_value);
   assign wide_new_prio  = PRIORITY_BUS_WIDTH'(req_data.item_priority);
   assign new_value      = wide_new_value[VALUE_WIDTH-1:0];
   assign new_prio       = wide_new_prio[PRIORITY_WIDTH-1:0];

   always_comb begin
      count_in     = count_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctrl.push_en) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.pop_en) begin
         count_in = count_ff - CW'(1);
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         if (req_data.kind == KIND_PUSH) begin
            status_in = full ? ST_FULL : ST_DONE;
         end else begin
            status_in = empty ? ST_EMPTY : ST_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= ST_DONE;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                      prev_stay;
      logic [VALUE_WIDTH-1:0]    prev_value, next_value;
      logic [PRIORITY_WIDTH-1:0] prev_prio, next_prio;

      if (i == 0) begin : g_head
         assign prev_stay  = 1'b1;
         assign prev_value = new_value;
         assign prev_prio  = new_prio;
      end else begin : g_body
         assign prev_stay  = cell_stay[i-1];
         assign prev_value = cell_value[i-1];
         assign prev_prio  = cell_prio[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_value = cell_value[i];
         assign next_prio  = cell_prio[i];
      end else begin : g_link
         assign next_value = cell_value[i+1];
         assign next_prio  = cell_prio[i+1];
      end

      psk_cell #(
         .VALUE_WIDTH   (VALUE_WIDTH),
         .PRIORITY_WIDTH(PRIORITY_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .new_value (new_value),
         .new_prio  (new_prio),
         .occupied  (count_ff > CW'(i)),
         .prev_stay (prev_stay),
         .prev_value(prev_value),
         .prev_prio (prev_prio),
         .next_value(next_value),
         .next_prio (next_prio),
         .stay      (cell_stay[i]),
         .value     (cell_value[i]),
         .prio      (cell_prio[i])
      );
   end

   assign wide_front_value = empty ? '0 : VALUE_BUS_WIDTH'(cell_value[0]);
   assign wide_front_prio  = empty ? '0 : PRIORITY_BUS_WIDTH'(cell_prio[0]);
   assign wide_count       = COUNT_BUS_WIDTH'(count_ff);

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_data.front_value    = wide_front_value[VALUE_FIELD_WIDTH-1:0];
   assign rsp_data.front_priority = wide_front_prio[PRIORITY_FIELD_WIDTH-1:0];
   assign rsp_data.entry_count    = wide_count[COUNT_FIELD_WIDTH-1:0];
   assign rsp_data.is_empty       = empty;
   assign rsp_data.status         = status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_beat_answered: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request beat got no response beat");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_FULL) |-> full)
      else $error("push rejected while the store was not full");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop_en |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("pop did not lower the entry count by one");

   a_front_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CW'(2)) |-> (cell_prio[0] >= cell_prio[1]))
      else $error("front entry has lower priority than the second");

endmodule

[rtl/psk_cell.sv]
// One slot of the sorted chain: holds a value and its priority and moves
// them to or from its neighbors on push and pop. Depends on psk_pkg.
module psk_cell #(
   parameter int VALUE_WIDTH    = psk_pkg::VALUE_WIDTH_DEF,
   parameter int PRIORITY_WIDTH = psk_pkg::PRIORITY_WIDTH_DEF
) (
   input  logic                      clock,
   input  psk_pkg::psk_ctrl_type     ctrl,
   input  logic [VALUE_WIDTH-1:0]    new_value,
   input  logic [PRIORITY_WIDTH-1:0] new_prio,
   input  logic                      occupied,
   input  logic                      prev_stay,
   input  logic [VALUE_WIDTH-1:0]    prev_value,
   input  logic [PRIORITY_WIDTH-1:0] prev_prio,
   input  logic [VALUE_WIDTH-1:0]    next_value,
   input  logic [PRIORITY_WIDTH-1:0] next_prio,
   output logic                      stay,
   output logic [VALUE_WIDTH-1:0]    value,
   output logic [PRIORITY_WIDTH-1:0] prio
);
   import psk_pkg::*;

   logic [VALUE_WIDTH-1:0]    value_ff, value_in;
   logic [PRIORITY_WIDTH-1:0] prio_ff, prio_in;

   // A stored entry of strictly higher priority keeps its place on a push.
   assign stay = occupied && (prio_ff > new_prio);

   always_comb begin
      value_in = value_ff;
      prio_in  = prio_ff;
      if (ctrl.push_en && !stay) begin
         if (prev_stay) begin
            value_in = new_value;
            prio_in  = new_prio;
         end else begin
            value_in = prev_value;
            prio_in  = prev_prio;
         end
      end else if (ctrl.pop_en) begin
         value_in = next_value;
         prio_in  = next_prio;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign value = value_ff;
   assign prio  = prio_ff;

endmodule
